// File: rtl/bayesian_power_estimator_unit_macros.svh
// Assertion macros shared by the estimator RTL.
`ifndef BAYESIAN_POWER_ESTIMATOR_UNIT_MACROS_SVH
`define BAYESIAN_POWER_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define BPE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpe assertion failed");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define BPE_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpe assertion failed");

`endif

// File: rtl/bpe_pkg.sv
// Shared types, operand codes and the microprogram of the power estimator.
package bpe_pkg;

    localparam int NEWTON_MAX_ITERS = 32;
    localparam int ITER_W = $clog2(NEWTON_MAX_ITERS + 1);
    localparam int PC_W = 7;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT,
        ALU_CONV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic flag;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        U_ADD,
        U_SUB,
        U_MUL,
        U_DIV,
        U_SQRT,
        U_CONV,
        U_BRZ,
        U_BRNEG,
        U_CLRCNT,
        U_LOOP,
        U_BRCONV,
        U_JMP,
        U_BRPASS,
        U_SETPASS,
        U_CLROK,
        U_DONE
    } uop_t;

    typedef struct packed {
        uop_t            op;
        logic [5:0]      dst;
        logic [5:0]      sa;
        logic [5:0]      sb;
        logic [PC_W-1:0] tgt;
    } instr_t;

    // Operand codes below 32 are state, inputs and constants; 32 and up are scratch memory.
    localparam logic [5:0] R_ZERO   = 6'd0;
    localparam logic [5:0] R_X      = 6'd1;
    localparam logic [5:0] R_K      = 6'd2;
    localparam logic [5:0] R_PL     = 6'd3;
    localparam logic [5:0] R_PM     = 6'd4;
    localparam logic [5:0] R_B      = 6'd5;
    localparam logic [5:0] R_A      = 6'd6;
    localparam logic [5:0] R_QA     = 6'd7;
    localparam logic [5:0] R_CHALF  = 6'd8;
    localparam logic [5:0] R_C3HALF = 6'd9;
    localparam logic [5:0] R_C2     = 6'd10;
    localparam logic [5:0] R_C3     = 6'd11;
    localparam logic [5:0] R_C4     = 6'd12;
    localparam logic [5:0] R_C8     = 6'd13;
    localparam logic [5:0] R_C9     = 6'd14;
    localparam logic [5:0] R_C12    = 6'd15;
    localparam logic [5:0] R_C14    = 6'd16;
    localparam logic [5:0] R_C18    = 6'd17;
    localparam logic [5:0] R_CM2    = 6'd18;
    localparam logic [5:0] R_MODE   = 6'd19;
    localparam logic [5:0] R_SPREAD = 6'd20;

    localparam logic [5:0] T_PML  = 6'd32;
    localparam logic [5:0] T_KX   = 6'd33;
    localparam logic [5:0] T_PMLM = 6'd34;
    localparam logic [5:0] T_KXX  = 6'd35;
    localparam logic [5:0] T_SUM  = 6'd36;
    localparam logic [5:0] T_LMM  = 6'd37;
    localparam logic [5:0] T_DIFF = 6'd38;
    localparam logic [5:0] T_LM   = 6'd39;
    localparam logic [5:0] T_QB   = 6'd40;
    localparam logic [5:0] T_QC   = 6'd41;
    localparam logic [5:0] T_TA   = 6'd42;
    localparam logic [5:0] T_TB   = 6'd43;
    localparam logic [5:0] T_DISC = 6'd44;
    localparam logic [5:0] T_A2   = 6'd45;
    localparam logic [5:0] T_B2   = 6'd46;
    localparam logic [5:0] T_L2   = 6'd47;
    localparam logic [5:0] T_M2   = 6'd48;
    localparam logic [5:0] T_M3   = 6'd49;
    localparam logic [5:0] T_M4   = 6'd50;
    localparam logic [5:0] T_K4   = 6'd51;
    localparam logic [5:0] T_K3   = 6'd52;
    localparam logic [5:0] T_K2   = 6'd53;
    localparam logic [5:0] T_K1   = 6'd54;
    localparam logic [5:0] T_K0   = 6'd55;
    localparam logic [5:0] T_D4   = 6'd56;
    localparam logic [5:0] T_D3   = 6'd57;
    localparam logic [5:0] T_D2   = 6'd58;
    localparam logic [5:0] T_X0   = 6'd59;
    localparam logic [5:0] T_XN   = 6'd60;
    localparam logic [5:0] T_DD   = 6'd61;
    localparam logic [5:0] T_D1   = 6'd62;

    localparam logic [PC_W-1:0] L_NONE    = 7'd0;
    localparam logic [PC_W-1:0] L_SKIPDIV = 7'd8;
    localparam logic [PC_W-1:0] L_NSTART  = 7'd76;
    localparam logic [PC_W-1:0] L_NTOP    = 7'd77;
    localparam logic [PC_W-1:0] L_NFAIL   = 7'd99;
    localparam logic [PC_W-1:0] L_NDONE   = 7'd100;
    localparam logic [PC_W-1:0] L_NSECOND = 7'd105;
    localparam logic [PC_W-1:0] L_FAIL    = 7'd108;
    localparam logic [PC_W-1:0] L_END     = 7'd111;

    function automatic instr_t mk(uop_t op, logic [5:0] d, logic [5:0] a, logic [5:0] b,
                                  logic [PC_W-1:0] t);
        instr_t i;
        i.op  = op;
        i.dst = d;
        i.sa  = a;
        i.sb  = b;
        i.tgt = t;
        return i;
    endfunction

    function automatic instr_t prog(logic [PC_W-1:0] pc);
        instr_t i;
        case (pc)
            // Posterior update.
            7'd0:   i = mk(U_MUL, T_PML, R_PL, R_PM, L_NONE);
            7'd1:   i = mk(U_MUL, T_KX, R_K, R_X, L_NONE);
            7'd2:   i = mk(U_MUL, T_PMLM, T_PML, R_PM, L_NONE);
            7'd3:   i = mk(U_MUL, T_KXX, T_KX, R_X, L_NONE);
            7'd4:   i = mk(U_ADD, R_PL, R_PL, R_K, L_NONE);
            7'd5:   i = mk(U_ADD, T_SUM, T_PML, T_KX, L_NONE);
            7'd6:   i = mk(U_BRZ, R_ZERO, R_PL, R_ZERO, L_SKIPDIV);
            7'd7:   i = mk(U_DIV, R_PM, T_SUM, R_PL, L_NONE);
            7'd8:   i = mk(U_MUL, T_LMM, R_PL, R_PM, L_NONE);
            7'd9:   i = mk(U_MUL, T_LMM, T_LMM, R_PM, L_NONE);
            7'd10:  i = mk(U_ADD, T_DIFF, T_PMLM, T_KXX, L_NONE);
            7'd11:  i = mk(U_SUB, T_DIFF, T_DIFF, T_LMM, L_NONE);
            7'd12:  i = mk(U_MUL, T_DIFF, R_CHALF, T_DIFF, L_NONE);
            7'd13:  i = mk(U_ADD, R_B, R_B, T_DIFF, L_NONE);
            // Quadratic, discriminant and mode.
            7'd14:  i = mk(U_MUL, T_LM, R_PL, R_PM, L_NONE);
            7'd15:  i = mk(U_SUB, T_QB, R_ZERO, T_LM, L_NONE);
            7'd16:  i = mk(U_MUL, T_TA, T_LM, R_PM, L_NONE);
            7'd17:  i = mk(U_MUL, T_TB, R_C2, R_B, L_NONE);
            7'd18:  i = mk(U_ADD, T_QC, T_TB, T_TA, L_NONE);
            7'd19:  i = mk(U_MUL, T_TA, T_QB, T_QB, L_NONE);
            7'd20:  i = mk(U_MUL, T_TB, R_C4, R_QA, L_NONE);
            7'd21:  i = mk(U_MUL, T_TB, T_TB, T_QC, L_NONE);
            7'd22:  i = mk(U_SUB, T_DISC, T_TA, T_TB, L_NONE);
            7'd23:  i = mk(U_BRZ, R_ZERO, R_PL, R_ZERO, L_FAIL);
            7'd24:  i = mk(U_BRNEG, R_ZERO, T_DISC, R_ZERO, L_FAIL);
            7'd25:  i = mk(U_SUB, T_TA, R_ZERO, T_QB, L_NONE);
            7'd26:  i = mk(U_SQRT, T_TB, T_DISC, R_ZERO, L_NONE);
            7'd27:  i = mk(U_SUB, T_TA, T_TA, T_TB, L_NONE);
            7'd28:  i = mk(U_ADD, T_TB, R_QA, R_QA, L_NONE);
            7'd29:  i = mk(U_DIV, R_MODE, T_TA, T_TB, L_NONE);
            // Powers.
            7'd30:  i = mk(U_MUL, T_A2, R_A, R_A, L_NONE);
            7'd31:  i = mk(U_MUL, T_B2, R_B, R_B, L_NONE);
            7'd32:  i = mk(U_MUL, T_L2, R_PL, R_PL, L_NONE);
            7'd33:  i = mk(U_MUL, T_M2, R_PM, R_PM, L_NONE);
            7'd34:  i = mk(U_MUL, T_M3, R_PM, T_M2, L_NONE);
            7'd35:  i = mk(U_MUL, T_M4, T_M2, T_M2, L_NONE);
            // Quartic coefficient 4.
            7'd36:  i = mk(U_MUL, T_TA, R_C4, T_A2, L_NONE);
            7'd37:  i = mk(U_MUL, T_TB, R_C14, R_A, L_NONE);
            7'd38:  i = mk(U_ADD, T_TA, T_TA, T_TB, L_NONE);
            7'd39:  i = mk(U_ADD, T_K4, T_TA, R_C12, L_NONE);
            // Coefficient 3.
            7'd40:  i = mk(U_MUL, T_TA, R_C4, R_PM, L_NONE);
            7'd41:  i = mk(U_MUL, T_TA, T_TA, R_A, L_NONE);
            7'd42:  i = mk(U_MUL, T_TA, T_TA, R_PL, L_NONE);
            7'd43:  i = mk(U_MUL, T_TB, R_C8, R_PM, L_NONE);
            7'd44:  i = mk(U_MUL, T_TB, T_TB, R_PL, L_NONE);
            7'd45:  i = mk(U_ADD, T_K3, T_TA, T_TB, L_NONE);
            // Coefficient 2.
            7'd46:  i = mk(U_MUL, T_TA, T_M2, T_L2, L_NONE);
            7'd47:  i = mk(U_MUL, T_TB, R_C4, T_M2, L_NONE);
            7'd48:  i = mk(U_MUL, T_TB, T_TB, R_A, L_NONE);
            7'd49:  i = mk(U_MUL, T_TB, T_TB, R_PL, L_NONE);
            7'd50:  i = mk(U_SUB, T_TA, T_TA, T_TB, L_NONE);
            7'd51:  i = mk(U_MUL, T_TB, R_C9, T_M2, L_NONE);
            7'd52:  i = mk(U_MUL, T_TB, T_TB, R_PL, L_NONE);
            7'd53:  i = mk(U_SUB, T_TA, T_TA, T_TB, L_NONE);
            7'd54:  i = mk(U_MUL, T_TB, R_C8, R_A, L_NONE);
            7'd55:  i = mk(U_MUL, T_TB, T_TB, R_B, L_NONE);
            7'd56:  i = mk(U_SUB, T_TA, T_TA, T_TB, L_NONE);
            7'd57:  i = mk(U_MUL, T_TB, R_C18, R_B, L_NONE);
            7'd58:  i = mk(U_SUB, T_K2, T_TA, T_TB, L_NONE);
            // Coefficient 1.
            7'd59:  i = mk(U_MUL, T_TA, R_CM2, T_M3, L_NONE);
            7'd60:  i = mk(U_MUL, T_TA, T_TA, T_L2, L_NONE);
            7'd61:  i = mk(U_MUL, T_TB, R_C4, R_PM, L_NONE);
            7'd62:  i = mk(U_MUL, T_TB, T_TB, R_B, L_NONE);
            7'd63:  i = mk(U_MUL, T_TB, T_TB, R_PL, L_NONE);
            7'd64:  i = mk(U_SUB, T_K1, T_TA, T_TB, L_NONE);
            // Coefficient 0.
            7'd65:  i = mk(U_MUL, T_TA, T_M4, T_L2, L_NONE);
            7'd66:  i = mk(U_MUL, T_TB, R_C4, T_M2, L_NONE);
            7'd67:  i = mk(U_MUL, T_TB, T_TB, R_B, L_NONE);
            7'd68:  i = mk(U_MUL, T_TB, T_TB, R_PL, L_NONE);
            7'd69:  i = mk(U_ADD, T_TA, T_TA, T_TB, L_NONE);
            7'd70:  i = mk(U_MUL, T_TB, R_C4, T_B2, L_NONE);
            7'd71:  i = mk(U_ADD, T_K0, T_TA, T_TB, L_NONE);
            // Derivative coefficients and first start point.
            7'd72:  i = mk(U_MUL, T_D4, R_C4, T_K4, L_NONE);
            7'd73:  i = mk(U_MUL, T_D3, R_C3, T_K3, L_NONE);
            7'd74:  i = mk(U_MUL, T_D2, R_C2, T_K2, L_NONE);
            7'd75:  i = mk(U_MUL, T_X0, R_CHALF, R_MODE, L_NONE);
            // Newton search.
            7'd76:  i = mk(U_CLRCNT, R_ZERO, R_ZERO, R_ZERO, L_NONE);
            7'd77:  i = mk(U_LOOP, R_ZERO, R_ZERO, R_ZERO, L_NFAIL);
            7'd78:  i = mk(U_MUL, T_TA, T_D4, T_X0, L_NONE);
            7'd79:  i = mk(U_ADD, T_TA, T_TA, T_D3, L_NONE);
            7'd80:  i = mk(U_MUL, T_TA, T_TA, T_X0, L_NONE);
            7'd81:  i = mk(U_ADD, T_TA, T_TA, T_D2, L_NONE);
            7'd82:  i = mk(U_MUL, T_TA, T_TA, T_X0, L_NONE);
            7'd83:  i = mk(U_ADD, T_DD, T_TA, T_K1, L_NONE);
            7'd84:  i = mk(U_BRZ, R_ZERO, T_DD, R_ZERO, L_NFAIL);
            7'd85:  i = mk(U_MUL, T_TA, T_K4, T_X0, L_NONE);
            7'd86:  i = mk(U_ADD, T_TA, T_TA, T_K3, L_NONE);
            7'd87:  i = mk(U_MUL, T_TA, T_TA, T_X0, L_NONE);
            7'd88:  i = mk(U_ADD, T_TA, T_TA, T_K2, L_NONE);
            7'd89:  i = mk(U_MUL, T_TA, T_TA, T_X0, L_NONE);
            7'd90:  i = mk(U_ADD, T_TA, T_TA, T_K1, L_NONE);
            7'd91:  i = mk(U_MUL, T_TA, T_TA, T_X0, L_NONE);
            7'd92:  i = mk(U_ADD, T_TA, T_TA, T_K0, L_NONE);
            7'd93:  i = mk(U_DIV, T_TA, T_TA, T_DD, L_NONE);
            7'd94:  i = mk(U_SUB, T_XN, T_X0, T_TA, L_NONE);
            7'd95:  i = mk(U_CONV, R_ZERO, T_X0, T_XN, L_NONE);
            7'd96:  i = mk(U_ADD, T_X0, T_XN, R_ZERO, L_NONE);
            7'd97:  i = mk(U_BRCONV, R_ZERO, R_ZERO, R_ZERO, L_NDONE);
            7'd98:  i = mk(U_JMP, R_ZERO, R_ZERO, R_ZERO, L_NTOP);
            7'd99:  i = mk(U_CLROK, R_ZERO, R_ZERO, R_ZERO, L_NONE);
            7'd100: i = mk(U_BRPASS, R_ZERO, R_ZERO, R_ZERO, L_NSECOND);
            7'd101: i = mk(U_ADD, T_D1, T_X0, R_ZERO, L_NONE);
            7'd102: i = mk(U_MUL, T_X0, R_C3HALF, R_MODE, L_NONE);
            7'd103: i = mk(U_SETPASS, R_ZERO, R_ZERO, R_ZERO, L_NONE);
            7'd104: i = mk(U_JMP, R_ZERO, R_ZERO, R_ZERO, L_NSTART);
            7'd105: i = mk(U_SUB, T_TA, T_X0, T_D1, L_NONE);
            7'd106: i = mk(U_MUL, R_SPREAD, R_CHALF, T_TA, L_NONE);
            7'd107: i = mk(U_JMP, R_ZERO, R_ZERO, R_ZERO, L_END);
            // Invalid estimate.
            7'd108: i = mk(U_CLROK, R_ZERO, R_ZERO, R_ZERO, L_NONE);
            7'd109: i = mk(U_ADD, R_MODE, R_ZERO, R_ZERO, L_NONE);
            7'd110: i = mk(U_ADD, R_SPREAD, R_ZERO, R_ZERO, L_NONE);
            default: i = mk(U_DONE, R_ZERO, R_ZERO, R_ZERO, L_NONE);
        endcase
        return i;
    endfunction

endpackage

// File: rtl/bpe_alu.sv
// Shared multi-cycle arithmetic unit: saturating add, subtract, multiply, divide, root, and the convergence test.
module bpe_alu
    import bpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  alu_req_t           req,
    input  logic signed [63:0] opa,
    input  logic signed [63:0] opb,
    output alu_rsp_t           rsp,
    output logic signed [63:0] result
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_ACC,
        A_DIV,
        A_SQRT,
        A_FIN,
        A_DONE
    } astate_t;

    localparam logic [63:0] CONV_SCALE = 64'd100000000;

    astate_t      state_reg;
    alu_op_t      op_reg;
    logic         neg_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pidx_reg;
    logic [6:0]   cnt_reg;
    logic [95:0]  work_reg;
    logic [63:0]  rem_reg;
    logic [95:0]  q_reg;
    logic [47:0]  root_reg;
    logic [49:0]  srem_reg;
    logic [64:0]  sum_reg;
    logic [63:0]  res_reg;
    logic         flag_reg;

    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [63:0]  sat_sum;
    logic [63:0]  sat_dif;
    logic [63:0]  conv_d;
    logic [31:0]  half_a;
    logic [31:0]  half_b;
    logic [127:0] pp_shifted;
    logic [64:0]  div_r;
    logic         div_ge;
    logic [51:0]  sq_r;
    logic [51:0]  sq_trial;
    logic         sq_ge;

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] sat_addsub(logic [63:0] a, logic [63:0] b, logic sub);
        logic [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] from_mag(logic neg, logic [63:0] m, logic over);
        if (!neg) begin
            return (over || m[63]) ? {1'b0, {63{1'b1}}} : m;
        end
        return (over || m[63]) ? {1'b1, 63'd0} : (64'd0 - m);
    endfunction

    always_comb begin
        mag_a   = magnitude(opa);
        mag_b   = magnitude(opb);
        sat_sum = sat_addsub(opa, opb, 1'b0);
        sat_dif = sat_addsub(opa, opb, 1'b1);
        conv_d  = sat_addsub(opb, opa, 1'b1);
        half_a  = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        half_b  = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        case (pidx_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd3:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {32'd0, pp_reg, 32'd0};
        endcase
        div_r    = {rem_reg, work_reg[95]};
        div_ge   = div_r >= {1'b0, ub_reg};
        sq_r     = {srem_reg, work_reg[95:94]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge    = sq_r >= sq_trial;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= A_IDLE;
        end else begin
            case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        op_reg   <= req.op;
                        neg_reg  <= opa[63] ^ opb[63];
                        // The convergence test multiplies |xn - x0| by 1e8.
                        ua_reg   <= (req.op == ALU_CONV) ? magnitude(conv_d) : mag_a;
                        ub_reg   <= (req.op == ALU_CONV) ? CONV_SCALE : mag_b;
                        acc_reg  <= '0;
                        cnt_reg  <= '0;
                        rem_reg  <= '0;
                        q_reg    <= '0;
                        root_reg <= '0;
                        srem_reg <= '0;
                        case (req.op)
                            ALU_ADD: begin
                                res_reg   <= sat_sum;
                                state_reg <= A_DONE;
                            end
                            ALU_SUB: begin
                                res_reg   <= sat_dif;
                                state_reg <= A_DONE;
                            end
                            ALU_MUL: begin
                                state_reg <= A_MUL;
                            end
                            ALU_DIV: begin
                                work_reg  <= {mag_a, 32'd0};
                                state_reg <= A_DIV;
                            end
                            ALU_SQRT: begin
                                work_reg  <= {opa, 32'd0};
                                state_reg <= A_SQRT;
                            end
                            ALU_CONV: begin
                                // |xn - x0| * 1e8 against |x0| + |xn|.
                                sum_reg   <= {1'b0, mag_a} + {1'b0, mag_b};
                                state_reg <= A_MUL;
                            end
                            default: begin
                                state_reg <= A_IDLE;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    pp_reg   <= half_a * half_b;
                    pidx_reg <= cnt_reg[1:0];
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_reg + pp_shifted;
                    end
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd3) begin
                        state_reg <= A_ACC;
                    end
                end
                A_ACC: begin
                    acc_reg   <= acc_reg + pp_shifted;
                    state_reg <= A_FIN;
                end
                A_DIV: begin
                    rem_reg  <= div_ge ? 64'(div_r - {1'b0, ub_reg}) : div_r[63:0];
                    q_reg    <= {q_reg[94:0], div_ge};
                    work_reg <= {work_reg[94:0], 1'b0};
                    cnt_reg  <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd95) begin
                        state_reg <= A_FIN;
                    end
                end
                A_SQRT: begin
                    srem_reg <= sq_ge ? 50'(sq_r - sq_trial) : sq_r[49:0];
                    root_reg <= {root_reg[46:0], sq_ge};
                    work_reg <= {work_reg[93:0], 2'b00};
                    cnt_reg  <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd47) begin
                        state_reg <= A_FIN;
                    end
                end
                A_FIN: begin
                    case (op_reg)
                        ALU_MUL:  res_reg <= from_mag(neg_reg, acc_reg[95:32],
                                                      acc_reg[127:96] != '0);
                        ALU_DIV:  res_reg <= from_mag(neg_reg, q_reg[63:0], q_reg[95:64] != '0);
                        ALU_SQRT: res_reg <= {16'd0, root_reg};
                        ALU_CONV: flag_reg <= acc_reg <= {63'd0, sum_reg};
                        default:  res_reg <= '0;
                    endcase
                    state_reg <= A_DONE;
                end
                A_DONE: begin
                    state_reg <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = (state_reg == A_DONE);
    assign rsp.flag = flag_reg;
    assign result   = res_reg;

endmodule

// File: rtl/bayesian_power_estimator_unit.sv
// Top level of the Bayesian power estimator: microcode sequencer, scratch memory, state.
//
// The slave stream carries one sample per transfer: sample_value (signed Q16.16) and
// sample_weight (unsigned Q16.16). Each transfer updates the normal-gamma posterior and
// produces one transfer on the master stream with power_mode and power_spread (signed
// Q32.32, saturated) in tdata and estimate_valid in tuser.
// All arithmetic runs on a single shared unit driven by a microprogram. It performs the
// posterior update, the quadratic and the quartic coefficients, then two Newton searches
// of up to 32 steps each; a zero precision sum skips straight to the invalid estimate.
// s_tready is high only while the sequencer is idle. The finished result sits in an output
// register; if the receiver stalls, the next sample is still accepted and computed, and the
// sequencer waits at its final step until the pending result has been transferred.
// Reset clears the posterior (count, precision sum, mean, scale) and empties the output.
`include "bayesian_power_estimator_unit_macros.svh"

module bayesian_power_estimator_unit
    import bpe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] sample_value, [63:32] sample_weight
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] power_mode, [127:64] power_spread
    output logic         m_tuser    // [0] estimate_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic                pass_reg;
    logic                ok_reg;
    logic                conv_reg;
    logic [31:0]         hc_reg;
    logic signed [63:0]  x_reg;
    logic signed [63:0]  k_reg;
    logic signed [63:0]  pl_reg;
    logic signed [63:0]  pm_reg;
    logic signed [63:0]  b_reg;
    logic signed [63:0]  mode_reg;
    logic signed [63:0]  spread_reg;
    logic                m_tvalid_reg;
    logic [127:0]        m_tdata_reg;
    logic                m_tuser_reg;

    logic signed [63:0]  mem [32];
    logic signed [63:0]  rda_reg;
    logic signed [63:0]  rdb_reg;

    instr_t              instr;
    logic signed [63:0]  opa;
    logic signed [63:0]  opb;
    logic signed [63:0]  a_val;
    logic signed [63:0]  qa_val;
    logic signed [33:0]  hc_m2;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic signed [63:0]  alu_result;
    logic                mem_we;
    logic [PC_W-1:0]     pc_inc;

    assign instr  = prog(pc_reg);
    assign pc_inc = pc_reg + PC_W'(1);

    // alpha = (n - 2) / 2 and the quadratic's leading term -(n + 1), saturated.
    always_comb begin
        hc_m2  = $signed({2'b00, hc_reg}) - 34'sd2;
        a_val  = {{30{hc_m2[33]}}, hc_m2} <<< 31;
        qa_val = hc_reg[31] ? {1'b1, 63'd0} : {~hc_reg, 32'd0};
    end

    function automatic logic signed [63:0] special(logic [5:0] code, logic signed [63:0] x,
                                                   logic signed [63:0] k,
                                                   logic signed [63:0] pl,
                                                   logic signed [63:0] pm,
                                                   logic signed [63:0] b,
                                                   logic signed [63:0] a,
                                                   logic signed [63:0] qa,
                                                   logic signed [63:0] md,
                                                   logic signed [63:0] sp);
        case (code)
            R_X:      return x;
            R_K:      return k;
            R_PL:     return pl;
            R_PM:     return pm;
            R_B:      return b;
            R_A:      return a;
            R_QA:     return qa;
            R_CHALF:  return 64'sh0000_0000_8000_0000;
            R_C3HALF: return 64'sh0000_0001_8000_0000;
            R_C2:     return 64'sh0000_0002_0000_0000;
            R_C3:     return 64'sh0000_0003_0000_0000;
            R_C4:     return 64'sh0000_0004_0000_0000;
            R_C8:     return 64'sh0000_0008_0000_0000;
            R_C9:     return 64'sh0000_0009_0000_0000;
            R_C12:    return 64'sh0000_000C_0000_0000;
            R_C14:    return 64'sh0000_000E_0000_0000;
            R_C18:    return 64'sh0000_0012_0000_0000;
            R_CM2:    return 64'shFFFF_FFFE_0000_0000;
            R_MODE:   return md;
            R_SPREAD: return sp;
            default:  return '0;
        endcase
    endfunction

    always_comb begin
        opa = instr.sa[5] ? rda_reg : special(instr.sa, x_reg, k_reg, pl_reg, pm_reg, b_reg,
                                              a_val, qa_val, mode_reg, spread_reg);
        opb = instr.sb[5] ? rdb_reg : special(instr.sb, x_reg, k_reg, pl_reg, pm_reg, b_reg,
                                              a_val, qa_val, mode_reg, spread_reg);
        alu_req.start = 1'b0;
        case (instr.op)
            U_ADD:   alu_req.op = ALU_ADD;
            U_SUB:   alu_req.op = ALU_SUB;
            U_MUL:   alu_req.op = ALU_MUL;
            U_DIV:   alu_req.op = ALU_DIV;
            U_SQRT:  alu_req.op = ALU_SQRT;
            U_CONV:  alu_req.op = ALU_CONV;
            default: alu_req.op = ALU_ADD;
        endcase
        if (state_reg == S_EXEC && instr.op inside {U_ADD, U_SUB, U_MUL, U_DIV, U_SQRT,
                                                     U_CONV}) begin
            alu_req.start = 1'b1;
        end
        mem_we = (state_reg == S_WAIT) && alu_rsp.done && instr.dst[5];
    end

    bpe_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (opa),
        .opb    (opb),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    // Scratch memory: one write port, two registered read ports.
    always_ff @(posedge clk) begin
        rda_reg <= mem[instr.sa[4:0]];
        rdb_reg <= mem[instr.sb[4:0]];
        if (mem_we) begin
            mem[instr.dst[4:0]] <= alu_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            iter_reg     <= '0;
            pass_reg     <= 1'b0;
            ok_reg       <= 1'b1;
            conv_reg     <= 1'b0;
            hc_reg       <= '0;
            x_reg        <= '0;
            k_reg        <= '0;
            pl_reg       <= '0;
            pm_reg       <= '0;
            b_reg        <= '0;
            mode_reg     <= '0;
            spread_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end else begin
            // The output register loads a finished result once it is free or being drained.
            if (state_reg == S_EMIT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {spread_reg, mode_reg};
                m_tuser_reg  <= ok_reg;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x_reg     <= {{16{s_tdata[31]}}, s_tdata[31:0], 16'd0};
                        k_reg     <= {16'd0, s_tdata[63:32], 16'd0};
                        if (hc_reg != '1) begin
                            hc_reg <= hc_reg + 32'd1;
                        end
                        pc_reg    <= '0;
                        pass_reg  <= 1'b0;
                        ok_reg    <= 1'b1;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_FETCH;
                    pc_reg    <= pc_inc;
                    case (instr.op)
                        U_BRZ: begin
                            if (opa == '0) begin
                                pc_reg <= instr.tgt;
                            end
                        end
                        U_BRNEG: begin
                            if (opa[63]) begin
                                pc_reg <= instr.tgt;
                            end
                        end
                        U_CLRCNT: begin
                            iter_reg <= '0;
                        end
                        U_LOOP: begin
                            if (iter_reg == ITER_W'(NEWTON_MAX_ITERS)) begin
                                pc_reg <= instr.tgt;
                            end else begin
                                iter_reg <= iter_reg + ITER_W'(1);
                            end
                        end
                        U_BRCONV: begin
                            if (conv_reg) begin
                                pc_reg <= instr.tgt;
                            end
                        end
                        U_JMP: begin
                            pc_reg <= instr.tgt;
                        end
                        U_BRPASS: begin
                            if (pass_reg) begin
                                pc_reg <= instr.tgt;
                            end
                        end
                        U_SETPASS: begin
                            pass_reg <= 1'b1;
                        end
                        U_CLROK: begin
                            ok_reg <= 1'b0;
                        end
                        U_DONE: begin
                            pc_reg    <= pc_reg;
                            state_reg <= S_EMIT;
                        end
                        default: begin
                            // Arithmetic: wait for the shared unit.
                            pc_reg    <= pc_reg;
                            state_reg <= S_WAIT;
                        end
                    endcase
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        if (instr.op == U_CONV) begin
                            conv_reg <= alu_rsp.flag;
                        end
                        case (instr.dst)
                            R_PL:     pl_reg     <= alu_result;
                            R_PM:     pm_reg     <= alu_result;
                            R_B:      b_reg      <= alu_result;
                            R_MODE:   mode_reg   <= alu_result;
                            R_SPREAD: spread_reg <= alu_result;
                            default:  ;
                        endcase
                        pc_reg    <= pc_inc;
                        state_reg <= S_FETCH;
                    end
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The shared unit only finishes while the sequencer waits on it.
    `BPE_ASSERT_IMP(a_done_in_wait, alu_rsp.done, state_reg == S_WAIT)
    // An accepted sample starts the microprogram from its first step.
    `BPE_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, state_reg == S_FETCH && pc_reg == '0)
    // A pending result is never overwritten while the receiver stalls.
    `BPE_ASSERT_NXT(a_emit_holds, state_reg == S_EMIT && m_tvalid_reg && !m_tready,
                    state_reg == S_EMIT && m_tvalid_reg)

endmodule

// File: test/bayesian_power_estimator_unit_test.sv
// Self-checking testbench for the Bayesian power estimator unit.
module bayesian_power_estimator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpe_pkg::*;

    localparam longint MAX_CYCLES = 64'd40000000;
    localparam int ITEM_COUNT = 650;
    localparam longint SAT_HI = 64'sh7FFFFFFFFFFFFFFF;
    localparam longint SAT_LO = 64'sh8000000000000000;
    localparam longint Q_ONE = 64'sd4294967296;
    localparam longint Q_HALF = 64'sd2147483648;

    typedef struct {
        logic [63:0] mode;
        logic [63:0] spread;
        logic        valid;
    } estimate_t;

    // Saturating Q32.32 arithmetic, evaluated with 130-bit intermediates.
    function automatic longint fx_sat(logic signed [129:0] v);
        if (v > 130'sd9223372036854775807) return SAT_HI;
        if (v < -130'sd9223372036854775808) return SAT_LO;
        return v[63:0];
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return fx_sat(130'(signed'(a)) + 130'(signed'(b)));
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return fx_sat(130'(signed'(a)) - 130'(signed'(b)));
    endfunction

    function automatic logic [63:0] fx_abs(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // The product magnitude is truncated toward zero before the sign is applied.
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        logic signed [129:0] m;
        p = 128'(fx_abs(a)) * 128'(fx_abs(b));
        m = 130'(p >> 32);
        return fx_sat(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        logic [127:0] q;
        logic signed [129:0] m;
        q = (128'(fx_abs(a)) << 32) / 128'(fx_abs(b));
        m = 130'(q);
        return fx_sat(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    function automatic longint fx_sqrt(longint v);
        logic [127:0] n;
        logic [63:0] r;
        logic [63:0] c;
        n = 128'(v) << 32;
        r = 0;
        for (int bit_pos = 47; bit_pos >= 0; bit_pos--)
        begin
            c = r | (64'd1 << bit_pos);
            if (128'(c) * 128'(c) <= n) r = c;
        end
        return r;
    endfunction

    function automatic longint quartic(longint x, longint c[5]);
        longint v;
        v = fx_add(fx_mul(c[4], x), c[3]);
        v = fx_add(fx_mul(v, x), c[2]);
        v = fx_add(fx_mul(v, x), c[1]);
        return fx_add(fx_mul(v, x), c[0]);
    endfunction

    function automatic longint quartic_slope(longint x, longint c[5]);
        longint v;
        v = fx_add(fx_mul(fx_mul(4 * Q_ONE, c[4]), x), fx_mul(3 * Q_ONE, c[3]));
        v = fx_add(fx_mul(v, x), fx_mul(2 * Q_ONE, c[2]));
        return fx_add(fx_mul(v, x), c[1]);
    endfunction

    // Newton search for one quartic root; clears found when it does not settle.
    function automatic longint find_root(longint x0, longint c[5], inout logic found);
        longint d;
        longint xn;
        logic [127:0] lhs;
        logic [127:0] rhs;
        for (int n = 0; n < NEWTON_MAX_ITERS; n++)
        begin
            d = quartic_slope(x0, c);
            if (d == 0) break;
            xn = fx_sub(x0, fx_div(quartic(x0, c), d));
            lhs = 128'(fx_abs(fx_sub(xn, x0))) * 128'd100000000;
            rhs = 128'(fx_abs(x0)) + 128'(fx_abs(xn));
            x0 = xn;
            if (lhs <= rhs) return xn;
        end
        found = 1'b0;
        return x0;
    endfunction

    class estimate_scoreboard;
        logic [31:0] sample_total;
        longint lambda_sum;
        longint mean;
        longint beta_sum;
        estimate_t pending[$];
        int mismatches;

        function new();
            sample_total = 0;
            lambda_sum = 0;
            mean = 0;
            beta_sum = 0;
            mismatches = 0;
        endfunction

        // Posterior update for one accepted sample, and the estimate it yields.
        function void note_sample(logic [31:0] xv, logic [31:0] kv);
            longint x, k, pl, pm, pml, kx, t, l, m, b, a, ai, qa, qb, qc, disc;
            longint a2, b2, l2, m2, m3, m4, d1, d2;
            longint c[5];
            estimate_t e;
            logic found;
            x = longint'(signed'(xv)) * 65536;
            k = longint'({32'd0, kv}) * 65536;
            pl = lambda_sum;
            pm = mean;
            found = 1'b1;
            e.mode = 0;
            e.spread = 0;
            pml = fx_mul(pl, pm);
            kx = fx_mul(k, x);
            if (sample_total != 32'hFFFFFFFF) sample_total++;
            lambda_sum = fx_add(lambda_sum, k);
            if (lambda_sum != 0) mean = fx_div(fx_add(pml, kx), lambda_sum);
            t = fx_sub(fx_add(fx_mul(pml, pm), fx_mul(kx, x)),
                       fx_mul(fx_mul(lambda_sum, mean), mean));
            beta_sum = fx_add(beta_sum, fx_mul(Q_HALF, t));
            l = lambda_sum;
            m = mean;
            b = beta_sum;
            a = (longint'({32'd0, sample_total}) - 2) * Q_HALF;
            ai = -(longint'({32'd0, sample_total}) + 1);
            qa = ai < -64'sd2147483648 ? SAT_LO : ai * Q_ONE;
            qb = fx_sub(0, fx_mul(l, m));
            qc = fx_add(fx_mul(2 * Q_ONE, b), fx_mul(fx_mul(l, m), m));
            disc = fx_sub(fx_mul(qb, qb), fx_mul(fx_mul(4 * Q_ONE, qa), qc));
            if (l == 0 || disc < 0)
            begin
                found = 1'b0;
            end
            else
            begin
                e.mode = fx_div(fx_sub(fx_sub(0, qb), fx_sqrt(disc)), fx_add(qa, qa));
                a2 = fx_mul(a, a);
                b2 = fx_mul(b, b);
                l2 = fx_mul(l, l);
                m2 = fx_mul(m, m);
                m3 = fx_mul(m, m2);
                m4 = fx_mul(m2, m2);
                c[4] = fx_add(fx_add(fx_mul(4 * Q_ONE, a2), fx_mul(14 * Q_ONE, a)), 12 * Q_ONE);
                c[3] = fx_add(fx_mul(fx_mul(fx_mul(4 * Q_ONE, m), a), l),
                              fx_mul(fx_mul(8 * Q_ONE, m), l));
                c[2] = fx_sub(fx_mul(m2, l2), fx_mul(fx_mul(fx_mul(4 * Q_ONE, m2), a), l));
                c[2] = fx_sub(c[2], fx_mul(fx_mul(9 * Q_ONE, m2), l));
                c[2] = fx_sub(c[2], fx_mul(fx_mul(8 * Q_ONE, a), b));
                c[2] = fx_sub(c[2], fx_mul(18 * Q_ONE, b));
                c[1] = fx_sub(fx_mul(fx_mul(-2 * Q_ONE, m3), l2),
                              fx_mul(fx_mul(fx_mul(4 * Q_ONE, m), b), l));
                c[0] = fx_add(fx_add(fx_mul(m4, l2),
                                     fx_mul(fx_mul(fx_mul(4 * Q_ONE, m2), b), l)),
                              fx_mul(4 * Q_ONE, b2));
                d1 = find_root(fx_mul(Q_HALF, e.mode), c, found);
                d2 = find_root(fx_mul(3 * Q_HALF, e.mode), c, found);
                e.spread = fx_mul(Q_HALF, fx_sub(d2, d1));
            end
            e.valid = found;
            pending.push_back(e);
        endfunction

        function void check_estimate(logic [127:0] data, logic user);
            estimate_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected estimate %h %b", data, user);
                return;
            end
            e = pending.pop_front();
            if (data[63:0] !== e.mode || data[127:64] !== e.spread || user !== e.valid)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("estimate mismatch: expected mode %h spread %h valid %b, got %h %h %b",
                             e.mode, e.spread, e.valid, data[63:0], data[127:64], user);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;

    estimate_scoreboard board;
    longint cycle_count;
    bit quiet_stretch;    // no random idling on either side while set
    bit hold_receiver;    // receiver holds off while set

    bayesian_power_estimator_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cycle counter and timeout.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLES)
            begin
                $display("bayesian_power_estimator_unit_test NOT OK");
                $finish;
            end
        end
    end

    // Offer one sample and hold it until the transfer completes; random idles come first.
    // Valid stays high from one sample to the next when no idle falls between them.
    task automatic send_sample(logic [31:0] xv, logic [31:0] kv);
        while (!quiet_stretch && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {kv, xv};
        do @(posedge clk); while (!s_tready);
        board.note_sample(xv, kv);
        @(negedge clk);
    endtask

    // Random sample value: mostly moderate, with whole-range values mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
            default: return $urandom_range(8 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 0;
            default: return $urandom_range(4 * 65536);
        endcase
    endfunction

    // Receiver: ready at random, or held off while hold_receiver is set.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= !hold_receiver && (quiet_stretch || $urandom_range(99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) board.check_estimate(m_tdata, m_tuser);
    end

    initial
    begin
        logic [31:0] values[12];
        logic [31:0] weights[12];
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        quiet_stretch = 1'b0;
        hold_receiver = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed samples: zero weight first (zero precision), field extremes, ordinary data.
        values = '{32'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'h00020000,
                   32'hFFFF0000, 32'h00018000, 32'h00030000, 32'hFFFFFFFF, 32'h00000001,
                   32'h00010000, 32'h00050000};
        weights = '{32'd0, 32'h00010000, 32'h00010000, 32'hFFFFFFFF, 32'h00000001,
                    32'h00008000, 32'h00010000, 32'h00020000, 32'h00010000, 32'hFFFFFFFF,
                    32'd0, 32'h00010000};
        for (int i = 0; i < 12; i++) send_sample(values[i], weights[i]);

        // Long receiver hold-off while samples keep coming, so the input stalls.
        fork
            begin
                hold_receiver = 1'b1;
                repeat (30000) @(posedge clk);
                hold_receiver = 1'b0;
            end
            for (int i = 0; i < 4; i++) send_sample(pick_value(), pick_weight());
        join
        s_tvalid <= 1'b0;

        // Sender pauses until everything outstanding is back.
        while (board.pending.size() != 0) @(posedge clk);
        @(negedge clk);

        for (int i = 0; i < ITEM_COUNT - 16; i++)
        begin
            quiet_stretch = (i >= 200 && i < 300);
            send_sample(pick_value(), pick_weight());
        end
        quiet_stretch = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.mismatches == 0)
            $display("bayesian_power_estimator_unit_test OK");
        else
            $display("bayesian_power_estimator_unit_test NOT OK");
        $finish;
    end

endmodule
